FILE: src/blc_pkg.sv
package blc_pkg;

    localparam int ENTRIES_DEF   = 64;
    localparam int ADDR_BITS_DEF = 48;
    localparam int FIELD_ADDR_W  = 48;
    localparam int FIELD_IDX_W   = 6;

    // operation codes
    localparam logic [2:0] FN_LOOKUP  = 3'd0;
    localparam logic [2:0] FN_INSERT  = 3'd1;
    localparam logic [2:0] FN_DELETE  = 3'd2;
    localparam logic [2:0] FN_TO_HEAD = 3'd3;
    localparam logic [2:0] FN_TO_TAIL = 3'd4;
    localparam logic [2:0] FN_PLUCK   = 3'd5;

    // status codes
    localparam logic [2:0] STS_OK     = 3'd0;
    localparam logic [2:0] STS_MISS   = 3'd1;
    localparam logic [2:0] STS_IN_USE = 3'd2;
    localparam logic [2:0] STS_CACHED = 3'd3;
    localparam logic [2:0] STS_EMPTY  = 3'd4;

    typedef struct packed {
        logic [2:0]              func;
        logic [FIELD_IDX_W-1:0]  entry_index;
        logic [FIELD_ADDR_W-1:0] block_addr;
        logic                    in_use;
    } cmd_t;

    typedef struct packed {
        logic [2:0]             status;
        logic [FIELD_IDX_W-1:0] result_entry;
    } rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISP,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_UNL_RD,
        S_UNL_WR,
        S_PUSH1,
        S_PUSH2,
        S_DONE
    } state_t;

endpackage

FILE: src/blc_ram.sv
module blc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: src/block_cache_lru_manager.sv
// Channel  | Ports               | Handshake
// ---------+---------------------+------------------------------------------
// command  | cmd (cmd_t)         | taken at a clock edge with start & !busy
// result   | rsp (rsp_t)         | valid for one cycle while done is high
//
// One item at a time; busy stays high from acceptance until the result cycle.
// Insert, pluck and moves need no walk. Lookup and delete walk the tag
// memory one entry at a time through its single read port, a read then a compare per
// entry, until a hit or the last entry. Reset clears the state machine, cached marks, list
// membership and list head; no clearing pass. The receiver cannot stall.
module block_cache_lru_manager #(
    parameter int ENTRIES   = blc_pkg::ENTRIES_DEF,
    parameter int ADDR_BITS = blc_pkg::ADDR_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  blc_pkg::cmd_t cmd,
    output logic          done,
    output blc_pkg::rsp_t rsp
);

    import blc_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int TAG_W = (ADDR_BITS < FIELD_ADDR_W) ? ADDR_BITS : FIELD_ADDR_W;

    state_t             state_reg, state_next;
    cmd_t               cmd_reg, cmd_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [IDX_W-1:0]   target_reg, target_next;
    logic [2:0]         status_reg, status_next;
    logic [FIELD_IDX_W-1:0] res_reg, res_next;
    logic [IDX_W-1:0]   head_reg, head_next;
    logic [IDX_W-1:0]   tail_reg, tail_next;
    logic               nonempty_reg, nonempty_next;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [ENTRIES-1:0] on_lru_reg, on_lru_next;

    logic               tag_we;
    logic [TAG_W-1:0]   tag_rdata;
    logic               nxt_we, prv_we;
    logic [IDX_W-1:0]   nxt_waddr, prv_waddr, nxt_wdata, prv_wdata;
    logic [IDX_W-1:0]   nxt_rdata, prv_rdata;

    logic               e_ok;
    logic [IDX_W-1:0]   e_idx;
    logic [TAG_W-1:0]   addr;
    logic               is_head, is_tail, is_move;

    assign e_ok    = 32'(cmd_reg.entry_index) < ENTRIES;
    assign e_idx   = IDX_W'(cmd_reg.entry_index);
    assign addr    = cmd_reg.block_addr[TAG_W-1:0];
    assign is_head = (target_reg == head_reg);
    assign is_tail = (target_reg == tail_reg);
    assign is_move = (cmd_reg.func == FN_TO_HEAD) || (cmd_reg.func == FN_TO_TAIL);

    blc_ram #(.WIDTH(TAG_W), .DEPTH(ENTRIES)) u_tag_ram (
        .clk   (clk),
        .we    (tag_we),
        .waddr (e_idx),
        .wdata (addr),
        .raddr (idx_reg),
        .rdata (tag_rdata)
    );

    blc_ram #(.WIDTH(IDX_W), .DEPTH(ENTRIES)) u_next_ram (
        .clk   (clk),
        .we    (nxt_we),
        .waddr (nxt_waddr),
        .wdata (nxt_wdata),
        .raddr (target_reg),
        .rdata (nxt_rdata)
    );

    blc_ram #(.WIDTH(IDX_W), .DEPTH(ENTRIES)) u_prev_ram (
        .clk   (clk),
        .we    (prv_we),
        .waddr (prv_waddr),
        .wdata (prv_wdata),
        .raddr (target_reg),
        .rdata (prv_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            head_reg     <= '0;
            tail_reg     <= '0;
            nonempty_reg <= 1'b0;
            valid_reg    <= '0;
            on_lru_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            nonempty_reg <= nonempty_next;
            valid_reg    <= valid_next;
            on_lru_reg   <= on_lru_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        idx_reg    <= idx_next;
        target_reg <= target_next;
        status_reg <= status_next;
        res_reg    <= res_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        idx_next      = idx_reg;
        target_next   = target_reg;
        status_next   = status_reg;
        res_next      = res_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        nonempty_next = nonempty_reg;
        valid_next    = valid_reg;
        on_lru_next   = on_lru_reg;
        tag_we        = 1'b0;
        nxt_we        = 1'b0;
        prv_we        = 1'b0;
        nxt_waddr     = target_reg;
        prv_waddr     = target_reg;
        nxt_wdata     = target_reg;
        prv_wdata     = target_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = cmd;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                status_next = STS_MISS;
                res_next    = '0;
                state_next  = S_DONE;
                unique case (cmd_reg.func) inside
                    FN_LOOKUP, FN_DELETE:
                    begin
                        idx_next   = '0;
                        state_next = S_SCAN_RD;
                    end
                    FN_INSERT:
                    begin
                        if (e_ok)
                        begin
                            if (valid_reg[e_idx])
                            begin
                                status_next = STS_CACHED;
                            end
                            else
                            begin
                                tag_we            = 1'b1;
                                valid_next[e_idx] = 1'b1;
                                status_next       = STS_OK;
                            end
                        end
                    end
                    FN_TO_HEAD, FN_TO_TAIL:
                    begin
                        if (e_ok)
                        begin
                            if (cmd_reg.in_use)
                            begin
                                status_next = STS_IN_USE;
                            end
                            else
                            begin
                                status_next = STS_OK;
                                target_next = e_idx;
                                if (cmd_reg.func == FN_TO_TAIL)
                                begin
                                    valid_next[e_idx] = 1'b0;
                                end
                                state_next = on_lru_reg[e_idx] ? S_UNL_RD : S_PUSH1;
                            end
                        end
                    end
                    FN_PLUCK:
                    begin
                        if (!nonempty_reg)
                        begin
                            status_next = STS_EMPTY;
                        end
                        else
                        begin
                            status_next          = STS_OK;
                            target_next          = tail_reg;
                            res_next             = FIELD_IDX_W'(tail_reg);
                            valid_next[tail_reg] = 1'b0;
                            state_next           = S_UNL_RD;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                if (valid_reg[idx_reg] && (tag_rdata == addr))
                begin
                    status_next = STS_OK;
                    state_next  = S_DONE;
                    if (cmd_reg.func == FN_DELETE)
                    begin
                        valid_next[idx_reg] = 1'b0;
                    end
                    else
                    begin
                        res_next    = FIELD_IDX_W'(idx_reg);
                        target_next = idx_reg;
                        if (on_lru_reg[idx_reg])
                        begin
                            state_next = S_UNL_RD;
                        end
                    end
                end
                else if (32'(idx_reg) == ENTRIES - 1)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SCAN_RD;
                end
            end
            S_UNL_RD:
            begin
                // links of the target come back next cycle
                state_next = S_UNL_WR;
            end
            S_UNL_WR:
            begin
                if (is_head && is_tail)
                begin
                    nonempty_next = 1'b0;
                end
                else if (is_head)
                begin
                    head_next = nxt_rdata;
                end
                else if (is_tail)
                begin
                    tail_next = prv_rdata;
                end
                if (!is_tail)
                begin
                    prv_we    = 1'b1;
                    prv_waddr = nxt_rdata;
                    prv_wdata = is_head ? nxt_rdata : prv_rdata;
                end
                if (!is_head)
                begin
                    nxt_we    = 1'b1;
                    nxt_waddr = prv_rdata;
                    nxt_wdata = is_tail ? prv_rdata : nxt_rdata;
                end
                on_lru_next[target_reg] = 1'b0;
                state_next = is_move ? S_PUSH1 : S_DONE;
            end
            S_PUSH1:
            begin
                if (cmd_reg.func == FN_TO_HEAD)
                begin
                    nxt_we = 1'b1;
                    if (nonempty_reg)
                    begin
                        prv_we    = 1'b1;
                        prv_waddr = head_reg;
                        nxt_wdata = head_reg;
                    end
                    else
                    begin
                        tail_next = target_reg;
                    end
                end
                else
                begin
                    prv_we = 1'b1;
                    if (nonempty_reg)
                    begin
                        nxt_we    = 1'b1;
                        nxt_waddr = tail_reg;
                        prv_wdata = tail_reg;
                    end
                    else
                    begin
                        head_next = target_reg;
                    end
                end
                state_next = S_PUSH2;
            end
            S_PUSH2:
            begin
                if (cmd_reg.func == FN_TO_HEAD)
                begin
                    prv_we    = 1'b1;
                    head_next = target_reg;
                end
                else
                begin
                    nxt_we    = 1'b1;
                    tail_next = target_reg;
                end
                nonempty_next           = 1'b1;
                on_lru_next[target_reg] = 1'b1;
                state_next              = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy             = (state_reg != S_IDLE);
    assign done             = (state_reg == S_DONE);
    assign rsp.status       = status_reg;
    assign rsp.result_entry = res_reg;

endmodule

FILE: dv/tb_block_cache_lru_manager.sv
`timescale 1ns / 1ps

module tb_block_cache_lru_manager;
    import blc_pkg::*;

    localparam int NENT = 64;
    localparam int N_RANDOM = 1740;

    logic  clk;
    logic  rst_n;
    logic  start;
    logic  busy;
    cmd_t  cmd;
    logic  done;
    rsp_t  rsp;

    block_cache_lru_manager DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .done  (done),
        .rsp   (rsp)
    );

    // Predicts responses from a private copy of the pool and LRU list.
    class lru_scoreboard;
        logic [47:0] tag_q[NENT];
        bit          cached[NENT];
        bit          linked[NENT];
        logic [5:0]  nxt[NENT];
        logic [5:0]  prv[NENT];
        logic [5:0]  head;
        logic [5:0]  tail;
        bit          filled;
        rsp_t        pending[$];
        int          errors;

        function new();
            for (int i = 0; i < NENT; i++)
            begin
                cached[i] = 0;
                linked[i] = 0;
            end
            head = 0;
            tail = 0;
            filled = 0;
            errors = 0;
        endfunction

        function bit find(logic [47:0] a, output logic [5:0] hit);
            for (int i = 0; i < NENT; i++)
            begin
                if (cached[i] && tag_q[i] == a)
                begin
                    hit = 6'(i);
                    return 1;
                end
            end
            return 0;
        endfunction

        function void unlink(logic [5:0] e);
            bit         is_h;
            bit         is_t;
            logic [5:0] nx;
            logic [5:0] pv;
            if (!linked[e])
                return;
            is_h = (e == head);
            is_t = (e == tail);
            nx = nxt[e];
            pv = prv[e];
            if (is_h && is_t)
                filled = 0;
            else if (is_h)
                head = nx;
            else if (is_t)
                tail = pv;
            else
            begin
                prv[nx] = pv;
                nxt[pv] = nx;
            end
            if (!is_h && is_t)
                nxt[pv] = pv;
            if (is_h && !is_t)
                prv[nx] = nx;
            linked[e] = 0;
        endfunction

        function void note_cmd(cmd_t c);
            rsp_t       r;
            logic [5:0] hit;
            logic [5:0] e;
            r.status = STS_MISS;
            r.result_entry = '0;
            e = c.entry_index;
            case (c.func) inside
                FN_LOOKUP:
                    if (find(c.block_addr, hit))
                    begin
                        unlink(hit);
                        r.status = STS_OK;
                        r.result_entry = hit;
                    end
                FN_INSERT:
                    if (cached[e])
                        r.status = STS_CACHED;
                    else
                    begin
                        tag_q[e] = c.block_addr;
                        cached[e] = 1;
                        r.status = STS_OK;
                    end
                FN_DELETE:
                    if (find(c.block_addr, hit))
                    begin
                        cached[hit] = 0;
                        r.status = STS_OK;
                    end
                FN_TO_HEAD, FN_TO_TAIL:
                    if (c.in_use)
                        r.status = STS_IN_USE;
                    else
                    begin
                        unlink(e);
                        if (c.func == FN_TO_HEAD)
                        begin
                            if (filled)
                            begin
                                prv[head] = e;
                                nxt[e] = head;
                            end
                            else
                            begin
                                tail = e;
                                nxt[e] = e;
                            end
                            prv[e] = e;
                            head = e;
                        end
                        else
                        begin
                            if (filled)
                            begin
                                nxt[tail] = e;
                                prv[e] = tail;
                            end
                            else
                            begin
                                head = e;
                                prv[e] = e;
                            end
                            nxt[e] = e;
                            tail = e;
                            cached[e] = 0;
                        end
                        filled = 1;
                        linked[e] = 1;
                        r.status = STS_OK;
                    end
                FN_PLUCK:
                    if (!filled)
                        r.status = STS_EMPTY;
                    else
                    begin
                        hit = tail;
                        cached[hit] = 0;
                        unlink(hit);
                        r.status = STS_OK;
                        r.result_entry = hit;
                    end
                default:
                    ;
            endcase
            pending.push_back(r);
        endfunction

        function void check_rsp(rsp_t got);
            rsp_t want;
            if (pending.size() == 0)
            begin
                $error("response with none expected: status %0d entry %0d",
                       got.status, got.result_entry);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                errors++;
            end
            if (got.result_entry !== want.result_entry)
            begin
                $error("result_entry: expected %0d, actual %0d",
                       want.result_entry, got.result_entry);
                errors++;
            end
        endfunction
    endclass

    lru_scoreboard sb;
    logic [47:0]   addr_pool[8];
    bit            quiet;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            sb.note_cmd(cmd);
        if (rst_n && done)
            sb.check_rsp(rsp);
    end

    initial
    begin
        #50ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Leaves start high on return; the caller drops it before a pause.
    task automatic send(logic [2:0] f, logic [5:0] e, logic [47:0] a, logic u);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        start <= 1'b1;
        cmd <= '{func: f, entry_index: e, block_addr: a, in_use: u};
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [47:0] pick_addr();
        logic [47:0] a;
        if ($urandom_range(0, 9) < 8)
            return addr_pool[$urandom_range(0, 7)];
        a = 48'({$urandom, $urandom});
        return a;
    endfunction

    initial
    begin
        logic [2:0] f;
        int         guard;
        sb = new();
        quiet = 0;
        start = 1'b0;
        cmd = '0;
        rst_n = 1'b0;
        addr_pool[0] = '0;
        addr_pool[1] = '1;
        addr_pool[2] = 48'h8000_0000_0000;
        addr_pool[3] = 48'h0000_0000_0001;
        for (int i = 4; i < 8; i++)
            addr_pool[i] = 48'({$urandom, $urandom});
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: empty list, misses, extremes, duplicates, held entries, unknown opcodes
        send(FN_PLUCK, 0, 0, 0);
        send(FN_LOOKUP, 0, '0, 0);
        send(FN_DELETE, 0, '1, 0);
        send(FN_INSERT, 0, '1, 0);
        send(FN_INSERT, 63, '1, 1);
        send(FN_INSERT, 0, '0, 0);
        send(FN_LOOKUP, 0, '1, 0);
        send(FN_INSERT, 5, '0, 0);
        send(FN_TO_HEAD, 63, 0, 0);
        send(FN_TO_HEAD, 5, 0, 0);
        send(FN_TO_TAIL, 0, 0, 0);
        send(FN_TO_HEAD, 7, 0, 1);
        send(FN_TO_TAIL, 7, 0, 1);
        send(FN_TO_HEAD, 5, 0, 0);
        send(FN_TO_TAIL, 63, 0, 0);
        send(FN_LOOKUP, 0, '1, 0);
        send(FN_DELETE, 0, '1, 0);
        send(3'd6, 1, 48'h123, 1);
        send(3'd7, 2, '1, 0);
        send(FN_PLUCK, 0, 0, 0);
        send(FN_PLUCK, 0, 0, 0);
        send(FN_PLUCK, 0, 0, 0);
        send(FN_PLUCK, 0, 0, 0);
        start <= 1'b0;

        // hold off until the pipeline drains
        guard = 0;
        while (sb.pending.size() != 0 && guard < 1000)
        begin
            @(negedge clk);
            guard++;
        end

        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == N_RANDOM - 200)
                quiet = 1;
            case ($urandom_range(0, 19)) inside
                0, 1, 2, 3:    f = FN_LOOKUP;
                4, 5, 6, 7:    f = FN_INSERT;
                8, 9:          f = FN_DELETE;
                10, 11, 12:    f = FN_TO_HEAD;
                13, 14:        f = FN_TO_TAIL;
                15, 16, 17:    f = FN_PLUCK;
                default:       f = 3'($urandom_range(6, 7));
            endcase
            send(f, 6'($urandom_range(0, 63)), pick_addr(), $urandom_range(0, 3) == 0);
        end
        start <= 1'b0;

        guard = 0;
        while (sb.pending.size() != 0 && guard < 5000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (2 * NENT + 10) @(negedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
